>>> sv/ipfr_pkg.sv
// Package for the IMU packet frame receiver: item types, frame codes and register indexes.
package ipfr_pkg;

    // Frame bytes.
    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] CMD_RATE  = 8'h52;
    localparam logic [7:0] CMD_ANGLE = 8'h53;

    // Each store holds this many bytes.
    localparam int STORE_BYTES = 8;
    localparam int COUNT_W     = 4;

    // Default number of payload bytes in one frame.
    localparam int PAYLOAD_BYTES_DEF = 8;

    // Configuration register indexes.
    localparam int          CFG_W          = 4;
    localparam logic [0:0]  CFG_RATE_LEN   = 1'b0;
    localparam logic [0:0]  CFG_ANGLE_LEN  = 1'b1;
    localparam logic [CFG_W-1:0] CFG_LEN_RST = 4'd8;

    // Item function codes.
    localparam logic FUNC_BYTE  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_COMMAND,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       overrun;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0]       rate_count;
        logic [COUNT_W-1:0]       angle_count;
        logic [8*STORE_BYTES-1:0] rate_data;
        logic [8*STORE_BYTES-1:0] angle_data;
    } t_out_item;

endpackage

>>> sv/imu_packet_frame_receiver.sv
// IMU packet frame receiver: frame parser, checksum, and rate/angle stores.
//
// This block takes one received serial byte per item and looks for frames made of a
// 0x55 header, a 0x52 (angular rate) or 0x53 (angle) command, PAYLOAD_BYTES payload
// bytes and a checksum equal to the 8-bit sum of header, command and payload. When the
// checksum matches, the payload is copied into the rate or angle store, clamped to the
// store length register (capped at the lesser of PAYLOAD_BYTES and 8), and that store's
// count is set to the number of bytes copied; bytes beyond the clamp keep old contents. A clear item
// zeroes both counts, and a byte marked as overrun changes nothing. Every accepted item
// produces exactly one result item holding both counts and both stores. The block takes
// one item per clock: all work for an item is done in the cycle it is accepted, and the
// result is shown from the state registers in the following cycle. The input is stalled
// only while a result is held back by a stall on the output side. The store length
// registers are written through the plain write port and should only change while the
// block is idle.
module imu_packet_frame_receiver
    import ipfr_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    // Most bytes one commit can copy: bounded by the payload and by the store size.
    localparam int COPY_MAX = (PAYLOAD_BYTES < STORE_BYTES) ? PAYLOAD_BYTES : STORE_BYTES;
    localparam int IDX_W    = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CNT_W    = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [CNT_W-1:0]   LAST_IDX  = CNT_W'(PAYLOAD_BYTES - 1);
    localparam logic [COUNT_W-1:0] COPY_MAXV = COUNT_W'(COPY_MAX);

    // Handshake.
    logic in_acc;
    logic out_acc;
    logic byte_acc;

    // Parser state.
    t_phase           r_phase, n_phase;
    logic             r_is_angle;
    logic [7:0]       r_sum;
    logic [CNT_W-1:0] r_pay_idx;
    logic [7:0]       r_hold [PAYLOAD_BYTES];

    // Stores and counts.
    logic [7:0]         r_rate_store  [STORE_BYTES];
    logic [7:0]         r_angle_store [STORE_BYTES];
    logic [COUNT_W-1:0] r_rate_fill;
    logic [COUNT_W-1:0] r_angle_fill;

    // Configuration.
    logic [CFG_W-1:0] r_rate_len;
    logic [CFG_W-1:0] r_angle_len;

    // Output register valid.
    logic r_out_valid, n_out_valid;

    // Decoded actions for the accepted byte.
    logic               cmd_ok;
    logic               hold_we;
    logic               sum_ok;
    logic               commit_rate;
    logic               commit_angle;
    logic [COUNT_W-1:0] rate_n;
    logic [COUNT_W-1:0] angle_n;

    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign byte_acc   = in_acc && (i_in_item.func == FUNC_BYTE) && !i_in_item.overrun;

    assign cmd_ok = (i_in_item.rx_byte == CMD_RATE) || (i_in_item.rx_byte == CMD_ANGLE);
    assign sum_ok = (i_in_item.rx_byte == r_sum);

    // Copy lengths: the register clamped to what a frame can supply.
    assign rate_n  = (r_rate_len  > COPY_MAXV) ? COPY_MAXV : r_rate_len;
    assign angle_n = (r_angle_len > COPY_MAXV) ? COPY_MAXV : r_angle_len;

    // Next parser phase.
    always_comb begin
        n_phase = r_phase;
        if (byte_acc) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (i_in_item.rx_byte == HDR_BYTE) begin
                        n_phase = PH_COMMAND;
                    end
                end
                PH_COMMAND: begin
                    n_phase = cmd_ok ? PH_PAYLOAD : PH_HEADER;
                end
                PH_PAYLOAD: begin
                    if (r_pay_idx == LAST_IDX) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_HEADER;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Actions taken in the current phase.
    always_comb begin
        hold_we      = 1'b0;
        commit_rate  = 1'b0;
        commit_angle = 1'b0;
        if (byte_acc) begin
            unique case (r_phase)
                PH_PAYLOAD: hold_we = 1'b1;
                PH_CHECK: begin
                    commit_rate  = sum_ok && !r_is_angle;
                    commit_angle = sum_ok && r_is_angle;
                end
                default: begin
                    hold_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_is_angle  <= 1'b0;
            r_sum       <= '0;
            r_pay_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (byte_acc && (r_phase == PH_COMMAND) && cmd_ok) begin
                r_is_angle <= (i_in_item.rx_byte == CMD_ANGLE);
                r_sum      <= HDR_BYTE + i_in_item.rx_byte;
                r_pay_idx  <= '0;
            end else if (hold_we) begin
                r_sum     <= r_sum + i_in_item.rx_byte;
                r_pay_idx <= r_pay_idx + 1'b1;
            end
        end
    end

    // Payload hold: written one byte per payload item, no reset.
    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_hold[r_pay_idx[IDX_W-1:0]] <= i_in_item.rx_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_len  <= CFG_LEN_RST;
            r_angle_len <= CFG_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATE_LEN:  r_rate_len  <= i_cfg_wdata;
                CFG_ANGLE_LEN: r_angle_len <= i_cfg_wdata;
                default:       r_rate_len  <= r_rate_len;
            endcase
        end
    end

    // Counts: a clear item zeroes both, a good frame sets its own store's count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_fill  <= '0;
            r_angle_fill <= '0;
        end else if (in_acc && (i_in_item.func == FUNC_CLEAR)) begin
            r_rate_fill  <= '0;
            r_angle_fill <= '0;
        end else begin
            if (commit_rate) begin
                r_rate_fill <= rate_n;
            end
            if (commit_angle) begin
                r_angle_fill <= angle_n;
            end
        end
    end

    // Store bytes: a byte is overwritten only when it lies inside the clamp.
    for (genvar gi = 0; gi < STORE_BYTES; gi++) begin : g_store
        if (gi < COPY_MAX) begin : g_copy
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rate_store[gi]  <= '0;
                    r_angle_store[gi] <= '0;
                end else begin
                    if (commit_rate && (COUNT_W'(gi) < rate_n)) begin
                        r_rate_store[gi] <= r_hold[gi];
                    end
                    if (commit_angle && (COUNT_W'(gi) < angle_n)) begin
                        r_angle_store[gi] <= r_hold[gi];
                    end
                end
            end
        end else begin : g_fixed
            // A frame never reaches these bytes, so they keep their reset value.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rate_store[gi]  <= '0;
                    r_angle_store[gi] <= '0;
                end
            end
        end
        assign o_out_item.rate_data[8*gi +: 8]  = r_rate_store[gi];
        assign o_out_item.angle_data[8*gi +: 8] = r_angle_store[gi];
    end

    // The state only moves on an accepted item, which cannot happen while a result
    // is held, so the result is read straight from the state registers.
    assign o_out_valid            = r_out_valid;
    assign o_out_item.rate_count  = r_rate_fill;
    assign o_out_item.angle_count = r_angle_fill;

    // A clear item leaves both counts at zero in its result.
    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_item.func == FUNC_CLEAR)
        |=> (o_out_item.rate_count == '0) && (o_out_item.angle_count == '0))
        else $error("counts not cleared by a clear item");

    // An overrun byte does not move the parser.
    a_overrun_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_item.func == FUNC_BYTE) && i_in_item.overrun
        |=> $stable(r_phase) && $stable(r_sum) && $stable(r_pay_idx))
        else $error("overrun byte changed the parser state");

    // Counts never exceed what one commit can copy.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rate_fill <= COPY_MAXV) && (r_angle_fill <= COPY_MAXV))
        else $error("store count above copy limit");

    // Every accepted item yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted item produced no result");

endmodule
